// ----- hw/rtl/utf8_sequence_filter_top_defines.svh -----
// assertion macros used by the filter top rtl
`ifndef UTF8_SEQUENCE_FILTER_TOP_DEFINES_SVH
`define UTF8_SEQUENCE_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define UTF8SF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8 filter check failed");

// next-cycle implication, checked outside reset
`define UTF8SF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8 filter check failed");

`else

`define UTF8SF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define UTF8SF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/utf8sf_pkg.sv -----
package utf8sf_pkg;

    // most result bytes one input byte can cause
    localparam int MAX_RESULTS    = 4;
    // default depth of the output queue (power of two, at least 8)
    localparam int DEF_OUTQ_DEPTH = 8;

    localparam logic [9:0] MAX_LENGTH_RESET = 10'd1023;

    // code point limits
    localparam logic [20:0] CP_LIMIT      = 21'h110000;
    localparam logic [20:0] CP_MIN_FOUR   = 21'h010000;
    localparam logic [15:0] CP_MIN_THREE  = 16'h0800;
    localparam logic [15:0] CP_SURR_LOW   = 16'hd800;
    localparam logic [15:0] CP_SURR_HIGH  = 16'he000;
    localparam logic [10:0] CP_MIN_TWO    = 11'h080;

    // sequence lengths
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // filter state carried from byte to byte
    typedef struct packed {
        logic [2:0][7:0] pend;     // held bytes of an open sequence
        logic [1:0]      cnt;      // number of held bytes
        logic [2:0]      exp_len;  // length of the open sequence, or zero
        logic [9:0]      pos;      // position of the next input byte
        logic            disc;     // dropping the tail after a cut
    } t_state;

    // result bytes made by one input byte
    typedef struct packed {
        logic [2:0]      num;
        logic [3:0][7:0] bytes;
    } t_result;

    // check a completed sequence from its lead and second byte
    function automatic logic seq_ok(logic [7:0] b0, logic [7:0] b1, logic [2:0] len);
        logic [20:0] u4;
        logic [15:0] u3;
        logic [10:0] u2;
        logic        ok;
        u4 = {b0[2:0], b1[5:0], 12'd0};
        u3 = {b0[3:0], b1[5:0], 6'd0};
        u2 = {b0[4:0], b1[5:0]};
        case (len)
            LEN_FOUR:  ok = (u4 < CP_LIMIT) && (u4 >= CP_MIN_FOUR);
            LEN_THREE: ok = (u3 >= CP_MIN_THREE) &&
                            !((u3 >= CP_SURR_LOW) && (u3 < CP_SURR_HIGH));
            default:   ok = (u2 >= CP_MIN_TWO);
        endcase
        return ok;
    endfunction

endpackage

// ----- hw/rtl/utf8sf_judge.sv -----
module utf8sf_judge
    import utf8sf_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic [9:0] i_max_length,
    output t_state     o_state,
    output t_result    o_result
);

    logic [2:0] lead_len;
    logic       held;
    logic       is_cont;
    logic [7:0] second;

    // sequence length announced by a lead byte
    always_comb begin
        case (i_byte) inside
            8'b110?_????: lead_len = LEN_TWO;
            8'b1110_????: lead_len = LEN_THREE;
            8'b1111_0???: lead_len = LEN_FOUR;
            default:      lead_len = LEN_NONE;
        endcase
    end

    assign held    = (i_state.exp_len != LEN_NONE) && (i_state.cnt != 2'd0);
    assign is_cont = (i_byte[7:6] == 2'b10);
    assign second  = (i_state.cnt >= 2'd2) ? i_state.pend[1] : i_byte;

    // next state and results for one byte
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_state.disc) begin
            // tail after a cut: drop everything, a zero ends the string
            if (i_byte == 8'd0) begin
                o_state.cnt     = 2'd0;
                o_state.exp_len = LEN_NONE;
                o_state.pos     = '0;
                o_state.disc    = 1'b0;
            end
        end else if (i_state.pos >= i_max_length) begin
            // cut point: one terminator replaces the byte
            o_result.num      = 3'd1;
            o_result.bytes[0] = 8'd0;
            o_state.cnt       = 2'd0;
            o_state.exp_len   = LEN_NONE;
            o_state.pos       = '0;
            o_state.disc      = (i_byte != 8'd0);
        end else begin
            o_state.pos = i_state.pos + 10'd1;
            if (held && is_cont) begin
                if (({1'b0, i_state.cnt} + 3'd1) >= i_state.exp_len) begin
                    // sequence complete: emit whole or drop whole
                    if (seq_ok(i_state.pend[0], second, i_state.exp_len)) begin
                        o_result.num = {1'b0, i_state.cnt} + 3'd1;
                        for (int i = 0; i < 3; i++) begin
                            o_result.bytes[i] = (2'(i) < i_state.cnt) ?
                                                i_state.pend[i] : i_byte;
                        end
                        o_result.bytes[3] = i_byte;
                    end
                    o_state.cnt     = 2'd0;
                    o_state.exp_len = LEN_NONE;
                end else if (i_state.cnt != 2'd3) begin
                    o_state.pend[i_state.cnt] = i_byte;
                    o_state.cnt               = i_state.cnt + 2'd1;
                end
            end else begin
                // nothing held, or a broken sequence: judge the byte afresh
                o_state.cnt     = 2'd0;
                o_state.exp_len = LEN_NONE;
                if (!i_byte[7]) begin
                    o_result.num      = 3'd1;
                    o_result.bytes[0] = i_byte;
                    if (i_byte == 8'd0) begin
                        o_state.pos  = '0;
                        o_state.disc = 1'b0;
                    end
                end else if (lead_len != LEN_NONE) begin
                    o_state.pend[0] = i_byte;
                    o_state.cnt     = 2'd1;
                    o_state.exp_len = lead_len;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/utf8sf_outq.sv -----
module utf8sf_outq
    import utf8sf_pkg::*;
#(
    parameter int DEPTH = DEF_OUTQ_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_result,
    input  logic       i_pop,
    output logic       o_room,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    logic [DEPTH-1:0][7:0] r_byte;
    logic [DEPTH-1:0]      r_last;
    logic [AW-1:0]         r_wr_ptr;
    logic [AW-1:0]         r_rd_ptr;
    logic [CW-1:0]         r_count;
    logic [2:0]            n_num;
    logic                  n_pop;

    assign n_num   = i_push ? i_result.num : 3'd0;
    assign n_pop   = i_pop && (r_count != '0);
    assign o_room  = (r_count <= CW'(DEPTH - MAX_RESULTS));
    assign o_valid = (r_count != '0);
    assign o_byte  = r_byte[r_rd_ptr];
    assign o_last  = r_last[r_rd_ptr];

    // result bytes of one transaction enter together, last flag on the final one
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (3'(i) < n_num) begin
                r_byte[r_wr_ptr + AW'(i)] <= i_result.bytes[i];
                r_last[r_wr_ptr + AW'(i)] <= (3'(i) == n_num - 3'd1);
            end
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + AW'(n_num);
            r_rd_ptr <= r_rd_ptr + AW'(n_pop);
            r_count  <= r_count + CW'(n_num) - CW'(n_pop);
        end
    end

endmodule

// ----- hw/rtl/utf8_sequence_filter_top.sv -----
// UTF-8 sequence filter. Takes one byte of a zero-terminated string per input
// transaction and passes on only bytes that form valid UTF-8; multi-byte
// sequences are held until complete and leave whole, while overlong forms,
// surrogates, code points above U+10FFFF, stray continuation bytes and bytes
// 0xF8-0xFF are dropped. A zero byte is passed on and restarts the block. At
// input position max_length (written on the cfg channel, reset 1023) the byte
// is replaced by a zero and the rest of the string up to its own zero is
// dropped. One byte is accepted every cycle while the output queue has room
// for four results; each input byte is judged in the cycle it is accepted and
// its results are written into the output queue, which sends one byte per
// cycle while i_ready is high, o_last_of_run marking the final byte of that
// input. A completed four-byte sequence is a four-byte burst at the output;
// the queue's single read port sets the sustained rate to one byte per cycle.
`include "utf8_sequence_filter_top_defines.svh"

module utf8_sequence_filter_top
    import utf8sf_pkg::*;
#(
    parameter int OUTQ_DEPTH = DEF_OUTQ_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [9:0] i_cfg_data
);

    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    logic [9:0] r_max_length;
    logic       in_fire;

    assign in_fire     = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // byte judgment
    utf8sf_judge u_judge (
        .i_state      (r_state),
        .i_byte       (i_data_byte),
        .i_max_length (r_max_length),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // output queue
    utf8sf_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_fire),
        .i_result (n_result),
        .i_pop    (i_ready),
        .o_room   (o_ready),
        .o_valid  (o_valid),
        .o_byte   (o_out_byte),
        .o_last   (o_last_of_run)
    );

    // truncation length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (i_cfg_valid) begin
            r_max_length <= i_cfg_data;
        end
    end

    // filter state, updated per accepted transaction; held bytes keep their value in reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cnt     <= 2'd0;
            r_state.exp_len <= LEN_NONE;
            r_state.pos     <= '0;
            r_state.disc    <= 1'b0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // checks
    `UTF8SF_ASSERT_IMPLY(a_tail_silent, i_clk, i_rst_n, in_fire && r_state.disc,
        n_result.num == 3'd0)
    `UTF8SF_ASSERT_IMPLY(a_open_count, i_clk, i_rst_n, r_state.exp_len != LEN_NONE,
        (r_state.cnt != 2'd0) && ({1'b0, r_state.cnt} < r_state.exp_len))
    `UTF8SF_ASSERT_IMPLY(a_idle_count, i_clk, i_rst_n, r_state.exp_len == LEN_NONE,
        r_state.cnt == 2'd0)
    `UTF8SF_ASSERT_NEXT(a_zero_restarts, i_clk, i_rst_n, in_fire && (i_data_byte == 8'd0),
        (r_state.pos == 10'd0) && !r_state.disc && (r_state.cnt == 2'd0))
    `UTF8SF_ASSERT_IMPLY(a_room_on_push, i_clk, i_rst_n, in_fire, n_result.num <= 3'd4)

endmodule
